// File: design/cvw_pkg.sv
`timescale 1ns / 1ps

package cvw_pkg;

    localparam int MAX_KERNEL    = 7;
    localparam int MAX_LINE      = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int LINE_ROWS     = MAX_KERNEL - 1;
    localparam int LINE_BITS     = LINE_ROWS * SAMPLE_BITS;
    localparam int COL_BITS      = $clog2(MAX_LINE);
    localparam int ROW_BITS      = 10;
    localparam int DIM_BITS      = 11;
    localparam int KSIZE_BITS    = 3;
    localparam int PROD_BITS     = 2 * SAMPLE_BITS;
    localparam int ROW_SUM_BITS  = PROD_BITS + 3;
    localparam int TOT_BITS      = ROW_SUM_BITS + 3;
    localparam int SUM_BITS      = 37;
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 64;
    localparam int OUT_USED_BITS = SUM_BITS + 2 * ROW_BITS;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_KERNEL_HEIGHT = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_KERNEL_WIDTH  = 2'd3;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_COEF  = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
    typedef logic signed [PROD_BITS-1:0]    prod_t;
    typedef logic signed [ROW_SUM_BITS-1:0] row_sum_t;
    typedef logic signed [TOT_BITS-1:0]     tot_t;
    typedef sample_t grid_t [MAX_KERNEL][MAX_KERNEL];

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                last;
    } meta_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        meta_t                      meta;
    } result_t;

endpackage

// File: design/cvw_line_ram.sv
`timescale 1ns / 1ps

module cvw_line_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/cvw_mac_array.sv
`timescale 1ns / 1ps

module cvw_mac_array (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  cvw_pkg::meta_t                 in_meta,
    input  cvw_pkg::grid_t                 window,
    input  cvw_pkg::grid_t                 coef,
    input  logic [cvw_pkg::KSIZE_BITS-1:0] kh,
    input  logic [cvw_pkg::KSIZE_BITS-1:0] kw,
    output logic                           out_valid,
    output cvw_pkg::result_t               out_item,
    output logic [1:0]                     busy
);

    cvw_pkg::prod_t    prod_next [cvw_pkg::MAX_KERNEL][cvw_pkg::MAX_KERNEL];
    cvw_pkg::prod_t    prod_reg  [cvw_pkg::MAX_KERNEL][cvw_pkg::MAX_KERNEL];
    cvw_pkg::row_sum_t row_next  [cvw_pkg::MAX_KERNEL];
    cvw_pkg::row_sum_t row_reg   [cvw_pkg::MAX_KERNEL];
    cvw_pkg::tot_t     tot_next;
    cvw_pkg::tot_t     tot_reg;
    cvw_pkg::meta_t    c_meta_reg;
    cvw_pkg::meta_t    d_meta_reg;
    cvw_pkg::meta_t    e_meta_reg;
    logic              c_valid_reg;
    logic              d_valid_reg;
    logic              e_valid_reg;

    // products: coef[k][l] against the sample kh-1-k rows up, kw-1-l columns left
    always_comb
    begin
        logic [cvw_pkg::KSIZE_BITS-1:0] ri;
        logic [cvw_pkg::KSIZE_BITS-1:0] ci;
        for (int k = 0; k < cvw_pkg::MAX_KERNEL; k++)
        begin
            for (int l = 0; l < cvw_pkg::MAX_KERNEL; l++)
            begin
                ri = cvw_pkg::KSIZE_BITS'(kh - 3'd1 - cvw_pkg::KSIZE_BITS'(k));
                ci = cvw_pkg::KSIZE_BITS'(kw - 3'd1 - cvw_pkg::KSIZE_BITS'(l));
                if ((cvw_pkg::KSIZE_BITS'(k) < kh) && (cvw_pkg::KSIZE_BITS'(l) < kw))
                begin
                    prod_next[k][l] = cvw_pkg::prod_t'(coef[k][l])
                                    * cvw_pkg::prod_t'(window[ri][ci]);
                end
                else
                begin
                    prod_next[k][l] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < cvw_pkg::MAX_KERNEL; k++)
        begin
            row_next[k] = '0;
            for (int l = 0; l < cvw_pkg::MAX_KERNEL; l++)
            begin
                row_next[k] = row_next[k] + cvw_pkg::row_sum_t'(prod_reg[k][l]);
            end
        end
    end

    always_comb
    begin
        tot_next = '0;
        for (int k = 0; k < cvw_pkg::MAX_KERNEL; k++)
        begin
            tot_next = tot_next + cvw_pkg::tot_t'(row_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= in_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        row_reg    <= row_next;
        tot_reg    <= tot_next;
        c_meta_reg <= in_meta;
        d_meta_reg <= c_meta_reg;
        e_meta_reg <= d_meta_reg;
    end

    assign out_valid     = e_valid_reg;
    assign out_item.sum  = tot_reg[cvw_pkg::SUM_BITS-1:0];
    assign out_item.meta = e_meta_reg;
    assign busy = 2'({1'b0, c_valid_reg} + {1'b0, d_valid_reg} + {1'b0, e_valid_reg});

endmodule

// File: design/cvw_out_fifo.sv
`timescale 1ns / 1ps

module cvw_out_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  cvw_pkg::result_t             push_item,
    input  logic                         pop,
    output logic                         not_empty,
    output cvw_pkg::result_t             head,
    output logic [cvw_pkg::FIFO_AW:0]    count
);

    cvw_pkg::result_t              entry [cvw_pkg::FIFO_DEPTH];
    logic [cvw_pkg::FIFO_AW-1:0]   wr_ptr_reg;
    logic [cvw_pkg::FIFO_AW-1:0]   rd_ptr_reg;
    logic [cvw_pkg::FIFO_AW:0]     count_reg;
    logic                          do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign head      = entry[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/conv2d_valid_window_core.sv
`timescale 1ns / 1ps

// 2D valid cross-correlation, kernel up to 7x7, raster-order pixel stream.
// Input channel s_axis: tuser 0 = pixel transfer, 1 = coefficient write.
// Output channel m_axis: one transfer per pixel that completes a window,
// tlast on the result of the last pixel of a frame.
// Config port: cfg_we/cfg_addr/cfg_wdata, written only while idle; the block
// itself leaves this to the user. A pixel's result goes through line RAM
// read, window shift, multiply, row sums and total sum into the output FIFO.
// Throughput: one item per cycle while s_axis_tready is high; set by the
// single read/write port pair of the line RAM, read and written back once
// per pixel. The output sits behind an 8-entry FIFO; s_axis_tready drops only
// when the FIFO plus the results in flight reach 8, so input keeps flowing
// while a result waits. A stalled receiver fills the FIFO, then stalls input.
// Reset clears position, window, coefficients and registers (width/height
// 1024, kernel 3x3). Line RAM is not cleared; frames fill it before use.
module conv2d_valid_window_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample[15:0], coef_row[18:16], coef_col[21:19], coef_value[37:22], zero pad
    input  logic [cvw_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // operation[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // conv_sum[36:0], out_row[46:37], out_col[56:47], zero pad
    output logic [cvw_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [cvw_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [cvw_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    logic [cvw_pkg::DIM_BITS-1:0]   image_width_reg;
    logic [cvw_pkg::DIM_BITS-1:0]   image_height_reg;
    logic [cvw_pkg::KSIZE_BITS-1:0] kernel_height_reg;
    logic [cvw_pkg::KSIZE_BITS-1:0] kernel_width_reg;

    logic [cvw_pkg::COL_BITS-1:0]   pixel_col_reg;
    logic [cvw_pkg::ROW_BITS-1:0]   pixel_row_reg;

    logic [cvw_pkg::DIM_BITS-1:0]   w_eff;
    logic [cvw_pkg::DIM_BITS-1:0]   h_eff;
    logic [cvw_pkg::KSIZE_BITS-1:0] kh_eff;
    logic [cvw_pkg::KSIZE_BITS-1:0] kw_eff;
    logic                           row_end;
    logic                           frame_end;
    logic                           produce;

    logic                           in_xfer;
    logic                           pix_xfer;
    logic                           coef_xfer;
    cvw_pkg::sample_t               in_sample;
    logic [2:0]                     in_coef_row;
    logic [2:0]                     in_coef_col;
    cvw_pkg::sample_t               in_coef_value;

    logic                           a_pix_reg;
    logic                           a_prod_reg;
    logic                           a_coef_reg;
    cvw_pkg::sample_t               a_sample_reg;
    logic [cvw_pkg::COL_BITS-1:0]   a_addr_reg;
    cvw_pkg::meta_t                 a_meta_reg;
    logic [2:0]                     a_coef_row_reg;
    logic [2:0]                     a_coef_col_reg;
    cvw_pkg::sample_t               a_coef_value_reg;

    logic                           b_prod_reg;
    cvw_pkg::meta_t                 b_meta_reg;

    logic [cvw_pkg::LINE_BITS-1:0]  rd_data;
    logic [cvw_pkg::LINE_BITS-1:0]  rd_eff;
    logic [cvw_pkg::LINE_BITS-1:0]  new_word;
    logic                           fwd_valid_reg;
    logic [cvw_pkg::COL_BITS-1:0]   fwd_addr_reg;
    logic [cvw_pkg::LINE_BITS-1:0]  fwd_word_reg;
    cvw_pkg::sample_t               column [cvw_pkg::MAX_KERNEL];

    cvw_pkg::grid_t                 window_reg;
    cvw_pkg::grid_t                 coef_reg;

    logic                           mac_valid;
    cvw_pkg::result_t               mac_item;
    logic [1:0]                     mac_busy;
    cvw_pkg::result_t               head;
    logic [cvw_pkg::FIFO_AW:0]      fifo_count;
    logic [cvw_pkg::FIFO_AW+1:0]    occupancy;

    assign in_sample     = s_axis_tdata[15:0];
    assign in_coef_row   = s_axis_tdata[18:16];
    assign in_coef_col   = s_axis_tdata[21:19];
    assign in_coef_value = s_axis_tdata[37:22];

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign pix_xfer  = in_xfer && (s_axis_tuser[0] == cvw_pkg::OP_PIXEL);
    assign coef_xfer = in_xfer && (s_axis_tuser[0] == cvw_pkg::OP_COEF);

    // out-of-range register values clamp
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = 11'd1;
        else if (image_width_reg > cvw_pkg::DIM_BITS'(cvw_pkg::MAX_LINE))
            w_eff = cvw_pkg::DIM_BITS'(cvw_pkg::MAX_LINE);
        else
            w_eff = image_width_reg;
        if (image_height_reg == '0)
            h_eff = 11'd1;
        else if (image_height_reg > cvw_pkg::DIM_BITS'(cvw_pkg::MAX_HEIGHT))
            h_eff = cvw_pkg::DIM_BITS'(cvw_pkg::MAX_HEIGHT);
        else
            h_eff = image_height_reg;
        kh_eff = (kernel_height_reg == '0) ? 3'd1 : kernel_height_reg;
        kw_eff = (kernel_width_reg == '0) ? 3'd1 : kernel_width_reg;
    end

    assign row_end   = ({1'b0, pixel_col_reg} >= (w_eff - 11'd1));
    assign frame_end = row_end && ({1'b0, pixel_row_reg} >= (h_eff - 11'd1));
    assign produce   = (({1'b0, pixel_row_reg} + 11'd1) >= {8'd0, kh_eff})
                    && (({1'b0, pixel_col_reg} + 11'd1) >= {8'd0, kw_eff});

    assign occupancy = (cvw_pkg::FIFO_AW+2)'(fifo_count)
                     + (cvw_pkg::FIFO_AW+2)'(a_prod_reg)
                     + (cvw_pkg::FIFO_AW+2)'(b_prod_reg)
                     + (cvw_pkg::FIFO_AW+2)'(mac_busy);
    assign s_axis_tready = (occupancy < (cvw_pkg::FIFO_AW+2)'(cvw_pkg::FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= cvw_pkg::DIM_BITS'(1024);
            image_height_reg  <= cvw_pkg::DIM_BITS'(1024);
            kernel_height_reg <= 3'd3;
            kernel_width_reg  <= 3'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cvw_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= cfg_wdata;
                cvw_pkg::REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_wdata;
                cvw_pkg::REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_wdata[2:0];
                cvw_pkg::REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // position and first stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_col_reg <= '0;
            pixel_row_reg <= '0;
            a_pix_reg     <= 1'b0;
            a_prod_reg    <= 1'b0;
            a_coef_reg    <= 1'b0;
            b_prod_reg    <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            a_pix_reg     <= pix_xfer;
            a_prod_reg    <= pix_xfer && produce;
            a_coef_reg    <= coef_xfer;
            b_prod_reg    <= a_prod_reg;
            fwd_valid_reg <= a_pix_reg;
            if (pix_xfer)
            begin
                priority if (frame_end)
                begin
                    pixel_col_reg <= '0;
                    pixel_row_reg <= '0;
                end
                else if (row_end)
                begin
                    pixel_col_reg <= '0;
                    pixel_row_reg <= pixel_row_reg + 1'b1;
                end
                else
                begin
                    pixel_col_reg <= pixel_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_sample_reg     <= in_sample;
        a_addr_reg       <= pixel_col_reg;
        a_meta_reg.row   <= cvw_pkg::ROW_BITS'(pixel_row_reg + 10'd1 - {7'd0, kh_eff});
        a_meta_reg.col   <= cvw_pkg::COL_BITS'(pixel_col_reg + 10'd1 - {7'd0, kw_eff});
        a_meta_reg.last  <= frame_end;
        a_coef_row_reg   <= in_coef_row;
        a_coef_col_reg   <= in_coef_col;
        a_coef_value_reg <= in_coef_value;
        b_meta_reg       <= a_meta_reg;
        if (a_pix_reg)
        begin
            fwd_addr_reg <= a_addr_reg;
            fwd_word_reg <= new_word;
        end
    end

    cvw_line_ram #(
        .WIDTH (cvw_pkg::LINE_BITS),
        .DEPTH (cvw_pkg::MAX_LINE)
    ) u_line_ram (
        .clk     (clk),
        .rd_en   (pix_xfer),
        .rd_addr (pixel_col_reg),
        .rd_data (rd_data),
        .wr_en   (a_pix_reg),
        .wr_addr (a_addr_reg),
        .wr_data (new_word)
    );

    // same column written back on the previous edge: take the fresh word
    assign rd_eff = (fwd_valid_reg && (fwd_addr_reg == a_addr_reg)) ? fwd_word_reg : rd_data;

    always_comb
    begin
        column[0] = a_sample_reg;
        for (int v = 1; v < cvw_pkg::MAX_KERNEL; v++)
        begin
            column[v] = rd_eff[(v-1)*cvw_pkg::SAMPLE_BITS +: cvw_pkg::SAMPLE_BITS];
        end
        for (int v = 0; v < cvw_pkg::LINE_ROWS; v++)
        begin
            new_word[v*cvw_pkg::SAMPLE_BITS +: cvw_pkg::SAMPLE_BITS] = column[v];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int v = 0; v < cvw_pkg::MAX_KERNEL; v++)
            begin
                for (int x = 0; x < cvw_pkg::MAX_KERNEL; x++)
                begin
                    window_reg[v][x] <= '0;
                    coef_reg[v][x]   <= '0;
                end
            end
        end
        else
        begin
            if (a_pix_reg)
            begin
                for (int v = 0; v < cvw_pkg::MAX_KERNEL; v++)
                begin
                    for (int x = cvw_pkg::MAX_KERNEL - 1; x >= 1; x--)
                    begin
                        window_reg[v][x] <= window_reg[v][x-1];
                    end
                    window_reg[v][0] <= column[v];
                end
            end
            if (a_coef_reg && (a_coef_row_reg < 3'(cvw_pkg::MAX_KERNEL))
                           && (a_coef_col_reg < 3'(cvw_pkg::MAX_KERNEL)))
            begin
                coef_reg[a_coef_row_reg][a_coef_col_reg] <= a_coef_value_reg;
            end
        end
    end

    cvw_mac_array u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_prod_reg),
        .in_meta   (b_meta_reg),
        .window    (window_reg),
        .coef      (coef_reg),
        .kh        (kh_eff),
        .kw        (kw_eff),
        .out_valid (mac_valid),
        .out_item  (mac_item),
        .busy      (mac_busy)
    );

    cvw_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mac_valid),
        .push_item (mac_item),
        .pop       (m_axis_tready),
        .not_empty (m_axis_tvalid),
        .head      (head),
        .count     (fifo_count)
    );

    assign m_axis_tdata = {(cvw_pkg::OUT_DATA_BITS-cvw_pkg::OUT_USED_BITS)'(0),
                           head.meta.col, head.meta.row, head.sum};
    assign m_axis_tlast = head.meta.last;

endmodule

// File: design/cvw_checker.sv
`timescale 1ns / 1ps

module cvw_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [cvw_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[cvw_pkg::OUT_DATA_BITS-1:cvw_pkg::OUT_USED_BITS] == '0))
        else $error("output pad bits not zero");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !in_xfer && !$past(in_xfer, 1) && !$past(in_xfer, 2)
        && !$past(in_xfer, 3) && !$past(in_xfer, 4) && !$past(in_xfer, 5)
        && !$past(in_xfer, 6) |-> s_axis_tready)
        else $error("input not ready with empty pipeline");

endmodule

bind conv2d_valid_window_core cvw_checker u_cvw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import cvw_pkg::*;

    typedef struct {
        logic signed [SUM_BITS-1:0] sum;
        logic [ROW_BITS-1:0]        row;
        logic [COL_BITS-1:0]        col;
        logic                       last;
    } conv_out_t;

    typedef struct {
        logic                       op;
        sample_t                    value;
        logic [2:0]                 crow;
        logic [2:0]                 ccol;
        logic                       known;
        logic signed [SUM_BITS-1:0] sum;
        logic                       last;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    conv2d_valid_window_core dut (.*);

    // golden copy of the block state
    sample_t line_mem [LINE_ROWS][MAX_LINE];
    sample_t win [MAX_KERNEL][MAX_KERNEL];
    sample_t coefs [MAX_KERNEL][MAX_KERNEL];
    int unsigned pcol, prow;
    logic [DIM_BITS-1:0] img_w, img_h;
    logic [KSIZE_BITS-1:0] ker_h, ker_w;

    conv_out_t sums_pending [$];
    int errors = 0;
    int items = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // Computes the result of one pixel and advances the raster position.
    task automatic predict_pixel(input sample_t s, output bit made, output conv_out_t res);
        int unsigned w, h, kh, kw, c;
        sample_t column [MAX_KERNEL];
        longint acc;
        bit row_end, frame_end;
        w = (img_w == 0) ? 1 : (img_w > MAX_LINE) ? MAX_LINE : img_w;
        h = (img_h == 0) ? 1 : (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
        kh = (ker_h == 0) ? 1 : ker_h;
        kw = (ker_w == 0) ? 1 : ker_w;
        c = (pcol >= MAX_LINE) ? MAX_LINE - 1 : pcol;
        column[0] = s;
        for (int v = 1; v < MAX_KERNEL; v++)
            column[v] = line_mem[v-1][c];
        for (int v = 1; v < MAX_KERNEL; v++)
            line_mem[v-1][c] = column[v-1];
        for (int v = 0; v < MAX_KERNEL; v++)
        begin
            for (int x = MAX_KERNEL - 1; x >= 1; x--)
                win[v][x] = win[v][x-1];
            win[v][0] = column[v];
        end
        row_end = (pcol >= w - 1);
        frame_end = row_end && (prow >= h - 1);
        made = (prow + 1 >= kh) && (pcol + 1 >= kw);
        if (made)
        begin
            acc = 0;
            for (int k = 0; k < kh; k++)
                for (int l = 0; l < kw; l++)
                    acc += longint'(win[kh-1-k][kw-1-l]) * longint'(coefs[k][l]);
            res.sum = acc[SUM_BITS-1:0];
            res.row = ROW_BITS'(prow + 1 - kh);
            res.col = COL_BITS'(pcol + 1 - kw);
            res.last = frame_end;
        end
        if (frame_end)
        begin
            pcol = 0;
            prow = 0;
        end
        else if (row_end)
        begin
            pcol = 0;
            prow++;
        end
        else
            pcol++;
    endtask

    // One input transfer; returns after it is accepted.
    task automatic send_item(input logic op, input sample_t val, input logic [2:0] crow,
                             input logic [2:0] ccol, output bit made, output conv_out_t res);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        if (op == OP_PIXEL)
            s_axis_tdata <= {2'b00, 16'($urandom), 3'($urandom), 3'($urandom), val};
        else
            s_axis_tdata <= {2'b00, val, ccol, crow, $unsigned(16'($urandom))};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items++;
        made = 0;
        if (op == OP_COEF)
        begin
            if (crow < MAX_KERNEL && ccol < MAX_KERNEL)
                coefs[crow][ccol] = val;
        end
        else
        begin
            predict_pixel(val, made, res);
            if (made)
                sums_pending.push_back(res);
        end
    endtask

    task automatic drain();
        while (sums_pending.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_geometry(input int w, input int h, input int kh, input int kw);
        int vals [4];
        s_axis_tvalid <= 1'b0;
        drain();
        vals = '{w, h, kh, kw};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_addr <= CFG_ADDR_BITS'(i);
            cfg_wdata <= CFG_DATA_BITS'(vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        img_w = CFG_DATA_BITS'(w);
        img_h = CFG_DATA_BITS'(h);
        ker_h = KSIZE_BITS'(kh);
        ker_w = KSIZE_BITS'(kw);
    endtask

    // A whole frame at the given geometry, coefficient writes sprinkled in.
    task automatic run_frame(input int w, input int h, input int kh, input int kw,
                             input int coef_pct);
        int n;
        bit made;
        conv_out_t res;
        set_geometry(w, h, kh, kw);
        n = ((w % 2048 == 0) ? 1 : (w > MAX_LINE) ? MAX_LINE : w) *
            ((h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < coef_pct)
                send_item(OP_COEF, sample_t'($urandom), 3'($urandom), 3'($urandom), made, res);
            send_item(OP_PIXEL, sample_t'($urandom), 3'd0, 3'd0, made, res);
        end
    endtask

    always @(posedge clk)
    begin
        conv_out_t want;
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles > 5000)
        begin
            $display("conv2d_valid_window_core test failed");
            $finish;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (sums_pending.size() == 0)
                report_mismatch("unexpected transfer", m_axis_tdata[SUM_BITS-1:0], 0);
            else
            begin
                want = sums_pending.pop_front();
                if ($signed(m_axis_tdata[SUM_BITS-1:0]) != want.sum)
                    report_mismatch("conv_sum", $signed(m_axis_tdata[SUM_BITS-1:0]), want.sum);
                if (m_axis_tdata[SUM_BITS +: ROW_BITS] != want.row)
                    report_mismatch("out_row", m_axis_tdata[SUM_BITS +: ROW_BITS], want.row);
                if (m_axis_tdata[SUM_BITS+ROW_BITS +: COL_BITS] != want.col)
                    report_mismatch("out_col", m_axis_tdata[SUM_BITS+ROW_BITS +: COL_BITS],
                                    want.col);
                if (m_axis_tlast != want.last)
                    report_mismatch("frame_last", m_axis_tlast, want.last);
            end
        end
    end

    stim_row_t directed [12] = '{
        '{OP_COEF,  -16'sd32768, 3'd0, 3'd0, 1'b0, '0, 1'b0},
        '{OP_COEF,   16'sd32767, 3'd0, 3'd1, 1'b0, '0, 1'b0},
        '{OP_COEF,  -16'sd32768, 3'd1, 3'd0, 1'b0, '0, 1'b0},
        '{OP_COEF,  -16'sd32768, 3'd1, 3'd1, 1'b0, '0, 1'b0},
        '{OP_COEF,   16'sd12345, 3'd7, 3'd7, 1'b0, '0, 1'b0},   // out of range, dropped
        '{OP_COEF,   16'sd1,     3'd0, 3'd7, 1'b0, '0, 1'b0},   // out of range, dropped
        '{OP_PIXEL, -16'sd32768, 3'd0, 3'd0, 1'b0, '0, 1'b0},
        '{OP_PIXEL, -16'sd32768, 3'd0, 3'd0, 1'b0, '0, 1'b0},
        '{OP_PIXEL, -16'sd32768, 3'd0, 3'd0, 1'b0, '0, 1'b0},
        '{OP_PIXEL, -16'sd32768, 3'd0, 3'd0, 1'b1, 37'sd2147516416, 1'b1},
        '{OP_PIXEL,  16'sd32767, 3'd0, 3'd0, 1'b0, '0, 1'b0},
        '{OP_PIXEL,  16'sd0,     3'd0, 3'd0, 1'b0, '0, 1'b0}
    };

    initial
    begin
        bit made;
        conv_out_t res;
        int mode;
        for (int v = 0; v < MAX_KERNEL; v++)
            for (int x = 0; x < MAX_KERNEL; x++)
            begin
                win[v][x] = '0;
                coefs[v][x] = '0;
            end
        for (int v = 0; v < LINE_ROWS; v++)
            for (int x = 0; x < MAX_LINE; x++)
                line_mem[v][x] = '0;
        pcol = 0;
        prow = 0;
        img_w = 1024;
        img_h = 1024;
        ker_h = 3;
        ker_w = 3;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_geometry(2, 2, 2, 2);
        foreach (directed[i])
        begin
            send_item(directed[i].op, directed[i].value, directed[i].crow, directed[i].ccol,
                      made, res);
            if (directed[i].known)
            begin
                void'(sums_pending.pop_back());
                res.sum = directed[i].sum;
                res.row = 0;
                res.col = 0;
                res.last = directed[i].last;
                sums_pending.push_back(res);
            end
        end
        for (int i = 0; i < 2; i++)
            send_item(OP_PIXEL, i ? 16'sd32767 : -16'sd1, 3'd0, 3'd0, made, res);

        // kernel bigger than the image, then out-of-range and extreme geometry
        run_frame(3, 3, 7, 7, 0);
        run_frame(0, 0, 0, 0, 0);
        run_frame(1, 9, 7, 1, 0);
        run_frame(7, 7, 7, 7, 10);

        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            while (items < 190 + 140 * (mode + 1))
                run_frame($urandom_range(12, 1), $urandom_range(8, 1),
                          $urandom_range(4), $urandom_range(4), 15);
        end

        s_axis_tvalid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && sums_pending.size() == 0)
            $display("conv2d_valid_window_core test passed");
        else
            $display("conv2d_valid_window_core test failed");
        $finish;
    end

endmodule

// File: filelist.f
design/cvw_pkg.sv
design/cvw_line_ram.sv
design/cvw_mac_array.sv
design/cvw_out_fifo.sv
design/conv2d_valid_window_core.sv
design/cvw_checker.sv
tb/tb.sv
